[src/rqpp_pkg.sv]
package rqpp_pkg;

   // Field widths of the request and response items
   localparam int SLOT_W = 6;
   localparam int PRI_W  = 7;
   localparam int CNT_W  = 32;
   localparam int REQ_W  = 2;
   localparam int STAT_W = 2;

   // Stream bus widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   // Response field positions inside rsp_tdata
   localparam int RSP_SLOT_LSB = STAT_W;
   localparam int RSP_PRI_LSB  = RSP_SLOT_LSB + SLOT_W;
   localparam int RSP_CNT_LSB  = RSP_PRI_LSB + PRI_W;

   localparam int DEF_NUM_SLOTS = 64;

   typedef logic [REQ_W-1:0]  req_code_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [PRI_W-1:0]  pri_type;

   // Request codes
   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_REMOVE = 2'd1;
   localparam req_code_type REQ_PICK   = 2'd2;

   // Status codes
   localparam status_type STAT_OK         = 2'd0;
   localparam status_type STAT_DUP        = 2'd1;
   localparam status_type STAT_NOT_QUEUED = 2'd2;
   localparam status_type STAT_EMPTY      = 2'd3;

endpackage

[src/run_queue_priority_picker_unit.sv]
// Priority run queue of NUM_SLOTS process slots. Each request (insert, remove or pick)
// returns exactly one response with a status, the picked slot and priority, and the
// running switch count. A pick returns the queued slot with the lowest priority number,
// oldest insertion first among equal priorities, and takes it off the queue. Slot priority
// and insertion rank live in a single-port-read, single-port-write memory that one shared
// read/compare datapath sweeps one slot per cycle; queued marks sit in flip-flops, so no
// clearing pass follows reset. An insert writes its entry; a remove reads the slot's rank
// then runs a rank renumbering sweep; a pick runs a best search sweep followed by a rank
// renumbering sweep; a rejected or empty request skips to the response. The response sits
// in an output register, so a new request is taken while the last response still waits.
module run_queue_priority_picker_unit
   import rqpp_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] proc_slot, [12:6] priority_req, [15:13] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [REQ_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [7:2] picked_slot, [14:8] picked_priority, [46:15] switch_count,
   // [47] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int EW = PRI_W + IW;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_RMRD = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DROP = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // Entry memory: {priority, rank}
   logic [EW-1:0] entry_mem [NUM_SLOTS];

   logic [2:0]           state_ff, state_in;
   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]     picks_ff, picks_in;
   logic                 rd_live_ff, rd_live_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   req_code_type         code_ff, code_in;
   status_type           status_ff, status_in;
   logic [IW-1:0]        target_ff, target_in;
   pri_type              ins_pri_ff, ins_pri_in;
   logic [IW-1:0]        drop_rank_ff, drop_rank_in;
   logic [CW-1:0]        scan_ix_ff, scan_ix_in;
   logic [IW-1:0]        rd_ix_ff, rd_ix_in;
   logic [EW-1:0]        rd_data_ff;
   logic                 best_found_ff, best_found_in;
   logic [IW-1:0]        best_ix_ff, best_ix_in;
   pri_type              best_pri_ff, best_pri_in;
   logic [IW-1:0]        best_rank_ff, best_rank_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   pri_type              rsp_pri_ff, rsp_pri_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                 mem_we;
   logic [IW-1:0]        mem_wa;
   logic [EW-1:0]        mem_wr_data;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;

   logic [SLOT_W-1:0]    req_slot;
   pri_type              req_pri;
   logic [IW-1:0]        req_ix;
   logic                 slot_ok;
   logic                 scan_issue;
   logic                 ev_valid;
   pri_type              ev_pri;
   logic [IW-1:0]        ev_rank;

   // Unpack the request
   assign req_slot = req_tdata[SLOT_W-1:0];
   assign req_pri  = req_tdata[SLOT_W+PRI_W-1:SLOT_W];
   assign req_ix   = IW'(req_slot);
   assign slot_ok  = (32'(req_slot) < 32'(NUM_SLOTS));

   // Sweep datapath: issue one read per cycle, judge the entry read last cycle
   assign scan_issue = (scan_ix_ff != CW'(NUM_SLOTS));
   assign ev_valid   = rd_live_ff && slot_valid_ff[rd_ix_ff];
   assign ev_pri     = rd_data_ff[EW-1:IW];
   assign ev_rank    = rd_data_ff[IW-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_pri_ff, rsp_slot_ff, rsp_status_ff};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      picks_in      = picks_ff;
      rd_live_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      code_in       = code_ff;
      status_in     = status_ff;
      target_in     = target_ff;
      ins_pri_in    = ins_pri_ff;
      drop_rank_in  = drop_rank_ff;
      scan_ix_in    = scan_ix_ff;
      rd_ix_in      = rd_ix_ff;
      best_found_in = best_found_ff;
      best_ix_in    = best_ix_ff;
      best_pri_in   = best_pri_ff;
      best_rank_in  = best_rank_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wa        = target_ff;
      mem_wr_data   = '0;
      rd_en         = 1'b0;
      rd_addr       = scan_ix_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               code_in    = req_tuser;
               target_in  = req_ix;
               ins_pri_in = req_pri;
               status_in  = STAT_OK;
               state_in   = S_FIN;
               unique case (req_tuser)
                  REQ_INSERT: begin
                     if (!slot_ok || slot_valid_ff[req_ix]) begin
                        status_in = STAT_DUP;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  REQ_REMOVE: begin
                     if (!slot_ok || !slot_valid_ff[req_ix]) begin
                        status_in = STAT_NOT_QUEUED;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_ix;
                        state_in = S_RMRD;
                     end
                  end
                  REQ_PICK: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        scan_ix_in    = '0;
                        best_found_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Append the slot at the tail of the insertion order
         S_INS: begin
            mem_we                   = 1'b1;
            mem_wa                   = target_ff;
            mem_wr_data              = {ins_pri_ff, IW'(count_ff)};
            slot_valid_in[target_ff] = 1'b1;
            count_in                 = count_ff + CW'(1);
            state_in                 = S_FIN;
         end

         // Latch the rank of the slot being removed
         S_RMRD: begin
            drop_rank_in = rd_data_ff[IW-1:0];
            scan_ix_in   = '0;
            state_in     = S_DROP;
         end

         // Search for the lowest priority number, oldest first on ties
         S_SCAN: begin
            if (scan_issue) begin
               rd_en      = 1'b1;
               rd_live_in = 1'b1;
               rd_ix_in   = scan_ix_ff[IW-1:0];
               scan_ix_in = scan_ix_ff + CW'(1);
            end
            if (ev_valid && (!best_found_ff || ev_pri < best_pri_ff ||
                             (ev_pri == best_pri_ff && ev_rank < best_rank_ff))) begin
               best_found_in = 1'b1;
               best_ix_in    = rd_ix_ff;
               best_pri_in   = ev_pri;
               best_rank_in  = ev_rank;
            end
            if (!scan_issue && !rd_live_ff) begin
               target_in    = best_ix_ff;
               drop_rank_in = best_rank_ff;
               ins_pri_in   = best_pri_ff;
               scan_ix_in   = '0;
               state_in     = S_DROP;
            end
         end

         // Close the gap in the ranks, then drop the slot
         S_DROP: begin
            if (scan_issue) begin
               rd_en      = 1'b1;
               rd_live_in = 1'b1;
               rd_ix_in   = scan_ix_ff[IW-1:0];
               scan_ix_in = scan_ix_ff + CW'(1);
            end
            if (ev_valid && ev_rank > drop_rank_ff) begin
               mem_we      = 1'b1;
               mem_wa      = rd_ix_ff;
               mem_wr_data = {ev_pri, ev_rank - IW'(1)};
            end
            if (!scan_issue && !rd_live_ff) begin
               slot_valid_in[target_ff] = 1'b0;
               count_in                 = count_ff - CW'(1);
               if (code_ff == REQ_PICK) begin
                  picks_in = picks_ff + CNT_W'(1);
               end
               state_in = S_FIN;
            end
         end

         // Hand the result to the output register once it is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = picks_ff;
               if (code_ff == REQ_PICK && status_ff == STAT_OK) begin
                  rsp_slot_in = SLOT_W'(target_ff);
                  rsp_pri_in  = ins_pri_ff;
               end else begin
                  rsp_slot_in = '0;
                  rsp_pri_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         count_ff      <= '0;
         picks_ff      <= '0;
         rd_live_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
         picks_ff      <= picks_in;
         rd_live_ff    <= rd_live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      status_ff     <= status_in;
      target_ff     <= target_in;
      ins_pri_ff    <= ins_pri_in;
      drop_rank_ff  <= drop_rank_in;
      scan_ix_ff    <= scan_ix_in;
      rd_ix_ff      <= rd_ix_in;
      best_found_ff <= best_found_in;
      best_ix_ff    <= best_ix_in;
      best_pri_ff   <= best_pri_in;
      best_rank_ff  <= best_rank_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

endmodule

[src/rqpp_checker.sv]
module rqpp_checker
   import rqpp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       req_take;
   status_type rsp_status;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_status = rsp_tdata[STAT_W-1:0];

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Report no slot or priority unless the request succeeded
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STAT_OK |->
         rsp_tdata[RSP_CNT_LSB-1:RSP_SLOT_LSB] == '0)
      else $error("slot or priority reported on a failed request");

   // Go busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("request taken while busy");

   // Keep the switch count on an empty pick
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid && rsp_status == STAT_EMPTY |->
         rsp_tdata[RSP_DATA_W-2:RSP_CNT_LSB] == $past(rsp_tdata[RSP_DATA_W-2:RSP_CNT_LSB]))
      else $error("switch count moved on an empty pick");

endmodule

bind run_queue_priority_picker_unit rqpp_checker u_rqpp_checker (.*);

[verif/tb_run_queue_priority_picker_unit.sv]
`timescale 1ns / 1ps

module tb_run_queue_priority_picker_unit;
   import rqpp_pkg::*;

   localparam int          SLOTS       = DEF_NUM_SLOTS;
   localparam req_code_type REQ_UNUSED = 2'd3;
   localparam int unsigned ITEM_TARGET = 1250;
   localparam int unsigned HOLD_START  = 20000;
   localparam int unsigned HOLD_CYCLES = 1500;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_WAIT  = 2 * SLOTS + 20;
   localparam int          PAD_W       = REQ_DATA_W - SLOT_W - PRI_W;

   typedef logic [SLOT_W-1:0] slot_type;

   // One response as the block should report it
   typedef struct {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic [PRI_W-1:0]  pri;
      logic [CNT_W-1:0]  switches;
   } outcome_type;

   typedef enum {RX_FLOW, RX_RANDOM, RX_STALL, RX_TOGGLE} rx_mode_type;

   // Shadow copy of the run queue plus the responses still owed by the block
   class run_queue_shadow_type;
      bit               queued   [SLOTS];
      bit [PRI_W-1:0]   slot_pri [SLOTS];
      int unsigned      slot_age [SLOTS];
      int unsigned      depth;
      bit [CNT_W-1:0]   switches;
      int unsigned      requests;
      int unsigned      errors;
      outcome_type      owed [$];

      // Take a queued slot out and close the gap in the insertion order
      function void unlink(int s);
         for (int i = 0; i < SLOTS; i++) begin
            if (queued[i] && slot_age[i] > slot_age[s]) begin
               slot_age[i]--;
            end
         end
         queued[s] = 1'b0;
         depth--;
      endfunction

      // Apply one accepted request and queue up the response it must produce
      function void log_request(req_code_type code, slot_type slot, pri_type pri);
         outcome_type o;
         int          best;
         o.status   = STAT_OK;
         o.slot     = '0;
         o.pri      = '0;
         best       = -1;
         case (code)
            REQ_INSERT: begin
               if (queued[slot]) begin
                  o.status = STAT_DUP;
               end else begin
                  queued[slot]   = 1'b1;
                  slot_pri[slot] = pri;
                  slot_age[slot] = depth;
                  depth++;
               end
            end
            REQ_REMOVE: begin
               if (!queued[slot]) begin
                  o.status = STAT_NOT_QUEUED;
               end else begin
                  unlink(slot);
               end
            end
            REQ_PICK: begin
               // lowest priority number wins, oldest insertion breaks ties
               for (int i = 0; i < SLOTS; i++) begin
                  if (queued[i] && (best < 0 || slot_pri[i] < slot_pri[best] ||
                      (slot_pri[i] == slot_pri[best] && slot_age[i] < slot_age[best]))) begin
                     best = i;
                  end
               end
               if (best < 0) begin
                  o.status = STAT_EMPTY;
               end else begin
                  o.slot = slot_type'(best);
                  o.pri  = slot_pri[best];
                  unlink(best);
                  switches++;
               end
            end
            default: begin
            end
         endcase
         o.switches = switches;
         owed.push_back(o);
         requests++;
      endfunction

      function void flag(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         errors++;
      endfunction

      // Compare one accepted response against the oldest owed one
      function void check_response(logic [RSP_DATA_W-1:0] d);
         outcome_type want;
         outcome_type got;
         got.status   = d[STAT_W-1:0];
         got.slot     = d[RSP_SLOT_LSB +: SLOT_W];
         got.pri      = d[RSP_PRI_LSB +: PRI_W];
         got.switches = d[RSP_CNT_LSB +: CNT_W];
         if (owed.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got %0h",
                     $time, d);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) flag("status", want.status, got.status);
         if (got.slot !== want.slot) flag("picked_slot", want.slot, got.slot);
         if (got.pri !== want.pri) flag("picked_priority", want.pri, got.pri);
         if (got.switches !== want.switches) flag("switch_count", want.switches, got.switches);
      endfunction

      // Random slot that is queued or free as asked, any slot if none fits
      function int random_slot(bit want_queued);
         int pool [$];
         for (int i = 0; i < SLOTS; i++) begin
            if (queued[i] == want_queued) pool.push_back(i);
         end
         if (pool.size() == 0) return $urandom_range(0, SLOTS - 1);
         return pool[$urandom_range(0, pool.size() - 1)];
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   run_queue_shadow_type shadow = new;
   int unsigned          cycle_count = 0;
   int unsigned          burst_left  = 0;

   run_queue_priority_picker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_response(rsp_tdata);
   end

   // Stall the response side in segments, with one long hold-off
   initial begin : rsp_stall
      rx_mode_type mode;
      int unsigned seg_len;
      bit          hold_done;
      hold_done = 1'b0;
      forever begin
         mode    = rx_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(1, 40);
         if (!hold_done && cycle_count >= HOLD_START) begin
            hold_done = 1'b1;
            mode      = RX_STALL;
            seg_len   = HOLD_CYCLES;
         end
         for (int k = 0; k < seg_len; k++) begin
            @(posedge clock);
            case (mode)
               RX_FLOW:   rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
               RX_STALL:  rsp_tready <= 1'b0;
               default:   rsp_tready <= 1'(k & 1);
            endcase
         end
      end
   end

   // Offer one request, idling between bursts, and hold it until taken
   task automatic offer(req_code_type code, slot_type slot, pri_type pri);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {{PAD_W{1'b0}}, pri, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.log_request(code, slot, pri);
   endtask

   initial begin : stimulus
      int          goal;
      int unsigned sel;
      req_code_type code;
      slot_type    slot;
      pri_type     pri;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_INSERT;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, duplicates, ties, middle removal, unused code
      offer(REQ_PICK, 6'd0, 7'd0);
      offer(REQ_REMOVE, 6'd0, 7'd0);
      offer(REQ_REMOVE, 6'd63, 7'd127);
      offer(REQ_INSERT, 6'd0, 7'd127);
      offer(REQ_INSERT, 6'd63, 7'd0);
      offer(REQ_INSERT, 6'd63, 7'd5);
      offer(REQ_INSERT, 6'd5, 7'd0);
      offer(REQ_INSERT, 6'd42, 7'd64);
      offer(REQ_INSERT, 6'd21, 7'd64);
      offer(REQ_UNUSED, 6'd63, 7'd127);
      offer(REQ_REMOVE, 6'd42, 7'd0);
      offer(REQ_INSERT, 6'd42, 7'd64);
      offer(REQ_PICK, 6'd63, 7'd127);
      offer(REQ_PICK, 6'd0, 7'd0);
      offer(REQ_PICK, 6'd0, 7'd0);
      offer(REQ_PICK, 6'd0, 7'd0);
      offer(REQ_REMOVE, 6'd0, 7'd0);
      offer(REQ_PICK, 6'd0, 7'd0);
      offer(REQ_UNUSED, 6'd0, 7'd0);
      offer(REQ_REMOVE, 6'd0, 7'd0);

      // Random: fill toward a goal depth, then drain, with some noise
      goal = SLOTS;
      while (shadow.requests < ITEM_TARGET) begin
         if (shadow.depth == goal) begin
            sel  = $urandom_range(0, 3);
            goal = (sel == 0) ? SLOTS : (sel == 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, SLOTS);
         end
         sel = $urandom_range(0, 9);
         if (sel < 4) pri = pri_type'($urandom_range(0, 3));
         else if (sel == 4) pri = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else pri = pri_type'($urandom_range(0, 127));
         if ($urandom_range(0, 99) < 10) begin
            code = req_code_type'($urandom_range(0, 3));
            slot = slot_type'($urandom_range(0, SLOTS - 1));
         end else if (shadow.depth < goal) begin
            code = REQ_INSERT;
            slot = slot_type'(shadow.random_slot(1'b0));
         end else if (shadow.depth == 0 || $urandom_range(0, 9) < 7) begin
            code = REQ_PICK;
            slot = slot_type'($urandom_range(0, SLOTS - 1));
         end else begin
            code = REQ_REMOVE;
            slot = slot_type'(shadow.random_slot(1'b1));
         end
         offer(code, slot, pri);
      end

      // Drain outstanding responses, then watch for strays
      req_tvalid <= 1'b0;
      while (shadow.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[run_queue_priority_picker_unit.f]
src/rqpp_pkg.sv
src/run_queue_priority_picker_unit.sv
src/rqpp_checker.sv
verif/tb_run_queue_priority_picker_unit.sv
